[hw/rtl/uer_pkg.sv]
package uer_pkg;

    // Field widths
    localparam int TICK_W   = 17;
    localparam int TRIG_W   = 10;
    localparam int GAP_W    = 17;
    localparam int SAMP_W   = 4;
    localparam int TPC_W    = 8;
    localparam int ECHO_W   = 16;
    localparam int SUM_W    = 19;
    localparam int DIST_W   = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    // Divider: dividend is the sum with eight fraction bits appended
    localparam int FRAC_W    = 8;
    localparam int DIVD_W    = SUM_W + FRAC_W;
    localparam int DIVR_W    = TPC_W + SAMP_W;
    localparam int DIV_STEPS = DIVD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM  = 4'd3;

    // Register reset values
    localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 10'd20;
    localparam logic [GAP_W-1:0]  GAP_TICKS_RST     = 17'd100000;
    localparam logic [SAMP_W-1:0] SAMPLE_COUNT_RST  = 4'd5;
    localparam logic [TPC_W-1:0]  TICKS_PER_CM_RST  = 8'd58;
    localparam logic [SAMP_W-1:0] MAX_SAMPLES       = 4'd8;

    typedef struct packed {
        logic start_req;
        logic echo;
    } in_t;

    typedef struct packed {
        logic              trigger;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_q8;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic in_load;
        logic step;
        logic div_step;
        logic out_load_step;
        logic out_load_div;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done_tick;
    } sts_t;

endpackage

[hw/rtl/uer_ctrl.sv]
module uer_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  uer_pkg::sts_t sts,
    output uer_pkg::cmd_t cmd
);
    import uer_pkg::*;

    typedef enum logic {
        C_RUN,
        C_DIV
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic              buf_valid_reg, buf_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              out_free;

    assign in_stall  = buf_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequence one tick request at a time, with the divider run on done ticks
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.in_load    = in_valid && !buf_valid_reg;
        buf_valid_next = buf_valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            C_RUN:
            begin
                if (buf_valid_reg && out_free)
                begin
                    cmd.step       = 1'b1;
                    buf_valid_next = 1'b0;
                    if (sts.done_tick)
                    begin
                        state_next = C_DIV;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cmd.out_load_step = 1'b1;
                        out_valid_next    = 1'b1;
                    end
                end
            end
            C_DIV:
            begin
                if (cnt_reg != DCNT_W'(DIV_STEPS))
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    cmd.out_load_div = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = C_RUN;
                end
            end
            default:
            begin
                state_next = C_RUN;
            end
        endcase
        if (cmd.in_load)
        begin
            buf_valid_next = 1'b1;
        end
    end

    // Hold controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_RUN;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Checks
    a_no_step_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_DIV) |-> !cmd.step)
        else $error("tick stepped while divider busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(cmd.out_load_step || cmd.out_load_div))
        else $error("result overwritten while stalled");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DCNT_W'(DIV_STEPS))
        else $error("divider count out of range");

    a_done_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.done_tick) |=> (state_reg == C_DIV && cnt_reg == '0))
        else $error("done tick did not start divider");

endmodule

[hw/rtl/uer_dpath.sv]
module uer_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  uer_pkg::in_t                     in_data,
    output uer_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  uer_pkg::cmd_t                    cmd,
    output uer_pkg::sts_t                    sts
);
    import uer_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS,
        PH_GAP
    } phase_t;

    // Configuration
    logic [TRIG_W-1:0] trig_ticks_reg;
    logic [GAP_W-1:0]  gap_ticks_reg;
    logic [SAMP_W-1:0] samp_cnt_reg;
    logic [TPC_W-1:0]  tpc_reg;

    // Tick state
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tc_reg, tc_next;
    logic [ECHO_W-1:0] et_reg, et_next;
    logic [SAMP_W-1:0] taken_reg, taken_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    in_t               buf_reg;
    logic              trig_now;

    // Divider
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dvr_reg, dvr_next;
    logic [DIVR_W:0]   rem_sh;
    out_t              out_reg, out_next;

    logic [SAMP_W-1:0] n_eff;
    logic [TPC_W-1:0]  tpc_eff;

    assign n_eff   = (samp_cnt_reg == '0) ? SAMP_W'(1)
                   : (samp_cnt_reg > MAX_SAMPLES) ? MAX_SAMPLES : samp_cnt_reg;
    assign tpc_eff = (tpc_reg == '0) ? TPC_W'(1) : tpc_reg;

    // Advance the tick state for the buffered request
    always_comb
    begin
        logic              done;
        logic              post_gap;
        logic [SUM_W:0]    sum_wide;
        phase_next = phase_reg;
        tc_next    = tc_reg;
        et_next    = et_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        trig_now   = 1'b0;
        done       = 1'b0;
        post_gap   = 1'b0;
        sum_wide   = '0;
        if (phase_reg == PH_IDLE && buf_reg.start_req)
        begin
            phase_next = PH_TRIG;
            tc_next    = '0;
            et_next    = '0;
            taken_next = '0;
            sum_next   = '0;
        end
        case (phase_next)
            PH_IDLE:
            begin
            end
            PH_TRIG:
            begin
                trig_now = 1'b1;
                tc_next  = tc_next + 1'b1;
                if (tc_next >= TICK_W'(trig_ticks_reg))
                begin
                    phase_next = PH_WAIT;
                    tc_next    = '0;
                end
            end
            PH_WAIT:
            begin
                if (buf_reg.echo)
                begin
                    et_next    = ECHO_W'(1);
                    phase_next = PH_MEAS;
                end
            end
            PH_MEAS:
            begin
                if (buf_reg.echo)
                begin
                    if (et_next != '1)
                    begin
                        et_next = et_next + 1'b1;
                    end
                end
                else
                begin
                    sum_wide   = {1'b0, sum_next} + (SUM_W + 1)'(et_next);
                    sum_next   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                    et_next    = '0;
                    taken_next = taken_next + 1'b1;
                    phase_next = PH_GAP;
                    tc_next    = '0;
                    post_gap   = (gap_ticks_reg == '0);
                end
            end
            PH_GAP:
            begin
                tc_next  = tc_next + 1'b1;
                post_gap = (tc_next >= gap_ticks_reg);
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        // End of gap: next trigger or result
        if (post_gap)
        begin
            tc_next = '0;
            if (taken_next >= n_eff)
            begin
                done       = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                phase_next = PH_TRIG;
            end
        end
        sts.done_tick = done;
    end

    // Restoring division, one quotient bit per step
    assign rem_sh = {rem_reg, quo_reg[DIVD_W-1]};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvr_next = dvr_reg;
        if (cmd.step)
        begin
            quo_next = {sum_next, FRAC_W'(0)};
            rem_next = '0;
            dvr_next = DIVR_W'(tpc_eff) * DIVR_W'(n_eff);
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, dvr_reg})
            begin
                rem_next = DIVR_W'(rem_sh - {1'b0, dvr_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIVR_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    // Select the result to load
    always_comb
    begin
        out_next = out_reg;
        if (cmd.out_load_step)
        begin
            out_next.trigger     = trig_now;
            out_next.busy_res    = (phase_next != PH_IDLE);
            out_next.done_res    = 1'b0;
            out_next.distance_q8 = '0;
        end
        else if (cmd.out_load_div)
        begin
            out_next.trigger     = 1'b0;
            out_next.busy_res    = 1'b0;
            out_next.done_res    = 1'b1;
            out_next.distance_q8 = quo_reg[DIST_W-1:0];
        end
    end

    assign out_data = out_reg;

    // Hold configuration and tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ticks_reg <= TRIGGER_TICKS_RST;
            gap_ticks_reg  <= GAP_TICKS_RST;
            samp_cnt_reg   <= SAMPLE_COUNT_RST;
            tpc_reg        <= TICKS_PER_CM_RST;
            phase_reg      <= PH_IDLE;
            tc_reg         <= '0;
            et_reg         <= '0;
            taken_reg      <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TRIGGER_TICKS: trig_ticks_reg <= cfg_data[TRIG_W-1:0];
                    CFG_GAP_TICKS:     gap_ticks_reg  <= cfg_data[GAP_W-1:0];
                    CFG_SAMPLE_COUNT:  samp_cnt_reg   <= cfg_data[SAMP_W-1:0];
                    CFG_TICKS_PER_CM:  tpc_reg        <= cfg_data[TPC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.step)
            begin
                phase_reg <= phase_next;
                tc_reg    <= tc_next;
                et_reg    <= et_next;
                taken_reg <= taken_next;
                sum_reg   <= sum_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            buf_reg <= in_data;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvr_reg <= dvr_next;
        out_reg <= out_next;
    end

endmodule

[hw/rtl/ultrasonic_echo_ranger.sv]
// Ultrasonic echo ranger.
// Each input request is one microsecond tick carrying start_req and the sampled
// echo level; each tick yields exactly one result with the trigger pin level,
// busy_res, done_res and, on the done tick, distance_q8 (cm, 8 fraction bits).
// Input and output channels use valid/stall; a request is taken when valid is
// high and stall is low. A one-entry input buffer and an output register part
// the two sides, so a new request is taken while a result waits downstream.
// A plain tick is stepped from the buffer into the output register; the buffer
// takes no new tick until it has been stepped. The tick that finishes a
// measurement runs a restoring divider, one quotient bit a cycle, and its
// result is loaded into the output register when the divider is through.
// While the output is stalled, the buffered tick waits and the result holds.
// Configuration goes through cfg_valid/cfg_ready (always ready), cfg_index
// 0..3 = trigger_ticks, gap_ticks, sample_count, ticks_per_cm; other indexes
// are dropped. Write only while idle.
// Reset clears both channels and the sequence, and reloads register defaults.
module ultrasonic_echo_ranger (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  uer_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output uer_pkg::out_t                   out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import uer_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    uer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    uer_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
